/* hw/rtl/lpcr_pkg.sv */
// Shared constants and types for the prefer-clean LRU replacement unit.
// No dependencies.
`default_nettype none

package lpcr_pkg;

	// Default geometry
	localparam int unsigned SETS_DEF     = 256;
	localparam int unsigned WAYS_DEF     = 4;
	localparam int unsigned TAG_BITS_DEF = 20;

	// Fixed field widths of the request, result and stamps
	localparam int unsigned SET_IN_W = 8;
	localparam int unsigned TAG_IN_W = 20;
	localparam int unsigned DIRTY_W  = 4;
	localparam int unsigned WAY_W    = 2;
	localparam int unsigned STAMP_W  = 32;

	typedef logic [STAMP_W-1:0] stamp_t;

	// Request kinds
	localparam logic KIND_ACCESS = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Victim policies
	localparam logic POLICY_PLAIN = 1'b0;
	localparam logic POLICY_CLEAN = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/lru_prefer_clean_replacement_unit.sv */
// A query passes stage 1 (registered row read) and the result register, waiting in
// stage 1 while an earlier result is untaken. A request is accepted only once the
// last has left stage 1, set by the read-modify-write of the stamp memory (one
// registered read, then one write-back or victim compare). Reset: counter and mode
// clear at once; then a clearing pass zeroes every set's stamps, taking no requests.
`default_nettype none

module lru_prefer_clean_replacement_unit #(
	parameter int unsigned SETS     = lpcr_pkg::SETS_DEF,
	parameter int unsigned WAYS     = lpcr_pkg::WAYS_DEF,
	parameter int unsigned TAG_BITS = lpcr_pkg::TAG_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          kind,
	input  wire logic [lpcr_pkg::SET_IN_W-1:0] set_index,
	input  wire logic [lpcr_pkg::TAG_IN_W-1:0] access_tag,
	input  wire logic [lpcr_pkg::TAG_IN_W-1:0] way0_tag,
	input  wire logic [lpcr_pkg::TAG_IN_W-1:0] way1_tag,
	input  wire logic [lpcr_pkg::TAG_IN_W-1:0] way2_tag,
	input  wire logic [lpcr_pkg::TAG_IN_W-1:0] way3_tag,
	input  wire logic [lpcr_pkg::DIRTY_W-1:0]  dirty_mask,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [lpcr_pkg::WAY_W-1:0]         victim_way
);

	localparam int unsigned IDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned CMP_W  = (TAG_BITS < lpcr_pkg::TAG_IN_W) ? TAG_BITS
	                                                                 : lpcr_pkg::TAG_IN_W;
	localparam int unsigned SET_IN_N = 2 ** lpcr_pkg::SET_IN_W;

	typedef logic [WAYS-1:0][lpcr_pkg::STAMP_W-1:0] row_t;

	// Control state
	logic                    policy_q;
	logic [lpcr_pkg::STAMP_W-1:0] cnt_q;
	logic                    clear_q;
	logic [IDX_W-1:0]        clr_idx_q;
	logic                    out_valid_q;
	logic [lpcr_pkg::WAY_W-1:0] victim_q;

	// Stage 1: request waiting on the row read
	logic                    v_s1;
	logic                    kind_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    hit_s1;
	logic [lpcr_pkg::WAY_W-1:0] hit_way_s1;
	lpcr_pkg::stamp_t        stamp_s1;
	logic [lpcr_pkg::DIRTY_W-1:0] dirty_s1;
	row_t                    row_s1;

	// Stamp memory, one row per set
	row_t                    mem [SETS];

	logic                    accept;
	logic                    done_s1;
	logic [IDX_W-1:0]        idx_in;
	logic [IDX_W-1:0]        set_map [SET_IN_N];
	logic [3:0][lpcr_pkg::TAG_IN_W-1:0] tags;
	logic                    hit;
	logic [lpcr_pkg::WAY_W-1:0] hit_way;
	logic                    mem_we;
	logic [IDX_W-1:0]        mem_wa;
	row_t                    mem_wd;
	row_t                    row_upd;
	logic [lpcr_pkg::WAY_W-1:0] plain_way;
	logic [lpcr_pkg::WAY_W-1:0] clean_way;
	logic                    clean_found;
	logic [lpcr_pkg::WAY_W-1:0] victim_nxt;

	// Fold the incoming set number onto the configured set count
	for (genvar g = 0; g < SET_IN_N; g++) begin : g_set_map
		assign set_map[g] = IDX_W'(g % SETS);
	end

	assign idx_in   = set_map[set_index];
	assign tags     = {way3_tag, way2_tag, way1_tag, way0_tag};
	assign accept   = in_valid && in_ready;
	assign in_ready = !clear_q && !v_s1;
	assign done_s1  = v_s1 && ((kind_s1 == lpcr_pkg::KIND_ACCESS) || !out_valid_q || out_ready);

	// Find the lowest matching way
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (tags[w][CMP_W-1:0] == access_tag[CMP_W-1:0]) begin
				hit     = 1'b1;
				hit_way = lpcr_pkg::WAY_W'(w);
			end
		end
	end

	// Replace the stamp of the hit way
	always_comb begin
		row_upd = row_s1;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_s1 && (hit_way_s1 == lpcr_pkg::WAY_W'(w))) begin
				row_upd[w] = stamp_s1;
			end
		end
	end

	// Pick victims under both policies
	always_comb begin
		lpcr_pkg::stamp_t pbest;
		lpcr_pkg::stamp_t cbest;
		plain_way   = '0;
		pbest       = row_s1[0];
		clean_way   = '0;
		cbest       = '0;
		clean_found = 1'b0;
		for (int w = 1; w < WAYS; w++) begin
			if (row_s1[w] < pbest) begin
				pbest     = row_s1[w];
				plain_way = lpcr_pkg::WAY_W'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!dirty_s1[w] && (!clean_found || (row_s1[w] <= cbest))) begin
				clean_found = 1'b1;
				cbest       = row_s1[w];
				clean_way   = lpcr_pkg::WAY_W'(w);
			end
		end
		victim_nxt = ((policy_q == lpcr_pkg::POLICY_CLEAN) && clean_found) ? clean_way
		                                                                   : plain_way;
	end

	// Memory write port: clearing pass or write-back of an access
	always_comb begin
		mem_we = clear_q || (done_s1 && (kind_s1 == lpcr_pkg::KIND_ACCESS));
		mem_wa = clear_q ? clr_idx_q : idx_s1;
		mem_wd = clear_q ? row_t'(0) : row_upd;
	end

	// Stamp memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (accept) begin
			row_s1 <= mem[idx_in];
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind;
			idx_s1     <= idx_in;
			hit_s1     <= hit && (kind == lpcr_pkg::KIND_ACCESS);
			hit_way_s1 <= hit_way;
			stamp_s1   <= cnt_q + lpcr_pkg::STAMP_W'(1);
			dirty_s1   <= dirty_mask;
		end
		if (done_s1 && (kind_s1 == lpcr_pkg::KIND_QUERY)) begin
			victim_q <= victim_nxt;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= lpcr_pkg::POLICY_PLAIN;
			cnt_q       <= '0;
			clear_q     <= 1'b1;
			clr_idx_q   <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				policy_q <= cfg_wr_data;
			end
			// advance the clearing sweep
			if (clear_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(SETS - 1)) begin
					clear_q <= 1'b0;
				end
			end
			// advance the time counter on access requests
			if (accept && (kind == lpcr_pkg::KIND_ACCESS)) begin
				cnt_q <= cnt_q + lpcr_pkg::STAMP_W'(1);
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (done_s1) begin
				v_s1 <= 1'b0;
			end
			// hold the result until taken
			if (done_s1 && (kind_s1 == lpcr_pkg::KIND_QUERY)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign victim_way = victim_q;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted request did not reach stage 1");

	a_no_clear_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(clear_q && v_s1))
		else $error("request in flight during clearing pass");

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(done_s1 && (kind_s1 == lpcr_pkg::KIND_QUERY)))
		else $error("result raised without a finished query");

	a_cnt_on_access: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(accept && (kind == lpcr_pkg::KIND_ACCESS)))
		else $error("time counter moved without an access");

	a_no_drop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(done_s1 && (kind_s1 == lpcr_pkg::KIND_QUERY)))
		else $error("query finished over a pending result");
`endif

endmodule

`default_nettype wire
